// ===== hdl/dahdr_pkg.sv =====
`default_nettype none

package dahdr_pkg;

  localparam int TIME_BITS       = 24;
  localparam int LEVEL_FRAC_BITS = 16;
  localparam int LEVEL_W         = LEVEL_FRAC_BITS + 1;
  localparam int PROD_W          = 2 * LEVEL_W;
  localparam int PHASE_W         = 3;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = (TIME_BITS > LEVEL_W) ? TIME_BITS : LEVEL_W;
  localparam int IN_TDATA_W      = 8;
  localparam int OUT_TDATA_W     = ((LEVEL_W + PHASE_W + 7) / 8) * 8;

  localparam int ONE_INT    = 1 << LEVEL_FRAC_BITS;
  localparam int TARGET_INT = (ONE_INT * 13 + 5) / 10;

  localparam logic [LEVEL_W-1:0] ONE_LEVEL     = LEVEL_W'(ONE_INT);
  localparam logic [LEVEL_W-1:0] TARGET_ATTACK = LEVEL_W'(TARGET_INT);
  localparam logic [PROD_W-1:0]  ROUND_HALF    = PROD_W'(ONE_INT / 2);

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE    = 3'd0,
    PH_DELAY   = 3'd1,
    PH_ATTACK  = 3'd2,
    PH_HOLD    = 3'd3,
    PH_DECAY   = 3'd4,
    PH_RELEASE = 3'd5
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY_TICKS     = 3'd0,
    CFG_ATTACK_COEF     = 3'd1,
    CFG_HOLD_TICKS      = 3'd2,
    CFG_DECAY_COEF      = 3'd3,
    CFG_SUSTAIN_LEVEL   = 3'd4,
    CFG_RELEASE_COEF    = 3'd5,
    CFG_RETRIGGER_TICKS = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] delay_ticks;
    logic [LEVEL_W-1:0]   attack_coef;
    logic [TIME_BITS-1:0] hold_ticks;
    logic [LEVEL_W-1:0]   decay_coef;
    logic [LEVEL_W-1:0]   sustain_level;
    logic [LEVEL_W-1:0]   release_coef;
    logic [TIME_BITS-1:0] retrigger_ticks;
  } env_cfg_t;

  typedef struct packed {
    phase_t               phase;
    logic [LEVEL_W-1:0]   level;
    logic [TIME_BITS-1:0] phase_timer;
    logic [TIME_BITS-1:0] key_timer;
    logic                 prev_gate;
  } env_state_t;

  localparam env_state_t STATE_RESET = '{
    phase:       PH_IDLE,
    level:       '0,
    phase_timer: '0,
    key_timer:   '0,
    prev_gate:   1'b0
  };

  localparam env_cfg_t CFG_RESET = '{
    delay_ticks:     '0,
    attack_coef:     ONE_LEVEL,
    hold_ticks:      '0,
    decay_coef:      ONE_LEVEL,
    sustain_level:   ONE_LEVEL,
    release_coef:    ONE_LEVEL,
    retrigger_ticks: '0
  };

endpackage

`default_nettype wire

// ===== hdl/dahdr_cfg.sv =====
`default_nettype none

module dahdr_cfg import dahdr_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output env_cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DELAY_TICKS:     cfg.delay_ticks     <= cfg_data[TIME_BITS-1:0];
        CFG_ATTACK_COEF:     cfg.attack_coef     <= cfg_data[LEVEL_W-1:0];
        CFG_HOLD_TICKS:      cfg.hold_ticks      <= cfg_data[TIME_BITS-1:0];
        CFG_DECAY_COEF:      cfg.decay_coef      <= cfg_data[LEVEL_W-1:0];
        CFG_SUSTAIN_LEVEL:   cfg.sustain_level   <= cfg_data[LEVEL_W-1:0];
        CFG_RELEASE_COEF:    cfg.release_coef    <= cfg_data[LEVEL_W-1:0];
        CFG_RETRIGGER_TICKS: cfg.retrigger_ticks <= cfg_data[TIME_BITS-1:0];
        default: ;  // unused index: drop the write
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dahdr_step.sv =====
`default_nettype none

module dahdr_step import dahdr_pkg::*; (
  input  wire env_cfg_t   cfg,
  input  wire env_state_t st,
  input  wire logic       gate,
  output env_state_t      st_next
);

  phase_t               ph;
  logic [LEVEL_W-1:0]   lv;
  logic [TIME_BITS-1:0] pt;
  logic [TIME_BITS-1:0] kt;
  logic [LEVEL_W-1:0]   lv_clamp;
  logic [LEVEL_W-1:0]   sus;
  logic                 sus_above;
  logic [LEVEL_W-1:0]   mul_c;
  logic [LEVEL_W-1:0]   mul_d;
  logic [PROD_W-1:0]    prod;
  logic [LEVEL_W-1:0]   scaled;
  logic [LEVEL_W:0]     attack_sum;

  // one shared multiplier; operands chosen by the phase after retrigger
  assign prod   = (PROD_W'(mul_c) * PROD_W'(mul_d)) + ROUND_HALF;
  assign scaled = prod[LEVEL_FRAC_BITS +: LEVEL_W];

  always_comb begin
    ph = st.phase;
    lv = st.level;
    pt = st.phase_timer;
    kt = st.key_timer;

    if (gate && (!st.prev_gate ||
                 (cfg.retrigger_ticks != '0 && kt >= cfg.retrigger_ticks))) begin
      ph = PH_DELAY;
      pt = '0;
      kt = '0;
    end

    lv_clamp  = (lv > ONE_LEVEL) ? ONE_LEVEL : lv;
    sus       = (cfg.sustain_level > ONE_LEVEL) ? ONE_LEVEL : cfg.sustain_level;
    sus_above = (sus >= lv);

    case (ph)
      PH_ATTACK: begin
        mul_c = cfg.attack_coef;
        mul_d = TARGET_ATTACK - lv_clamp;
      end
      PH_DECAY: begin
        mul_c = cfg.decay_coef;
        mul_d = sus_above ? (sus - lv) : (lv - sus);
      end
      default: begin
        mul_c = cfg.release_coef;
        mul_d = lv;
      end
    endcase

    attack_sum = {1'b0, lv_clamp} + {1'b0, scaled};

    unique case (ph)
      PH_DELAY: begin
        if (pt >= cfg.delay_ticks) begin
          ph = PH_ATTACK;
          pt = '0;
        end
      end
      PH_ATTACK: begin
        if (cfg.attack_coef >= ONE_LEVEL || attack_sum >= {1'b0, ONE_LEVEL}) begin
          lv = ONE_LEVEL;
          ph = PH_HOLD;
          pt = '0;
        end else begin
          lv = attack_sum[LEVEL_W-1:0];
        end
      end
      PH_HOLD: begin
        if (pt >= cfg.hold_ticks) begin
          ph = PH_DECAY;
          pt = '0;
        end
      end
      PH_DECAY: begin
        // gate low still applies this tick's decay step
        if (!gate) begin
          ph = PH_RELEASE;
          pt = '0;
        end
        if (cfg.decay_coef >= ONE_LEVEL) begin
          lv = sus;
        end else if (sus_above) begin
          lv = lv + scaled;
        end else begin
          lv = lv - scaled;
        end
      end
      PH_RELEASE: begin
        if (cfg.release_coef >= ONE_LEVEL) begin
          lv = '0;
          ph = PH_IDLE;
          pt = '0;
        end else begin
          lv = lv - scaled;
        end
      end
      default: begin
        ph = PH_IDLE;
      end
    endcase

    st_next.phase       = ph;
    st_next.level       = lv;
    st_next.phase_timer = (pt == '1) ? pt : pt + 1'b1;
    st_next.key_timer   = (kt == '1) ? kt : kt + 1'b1;
    st_next.prev_gate   = gate;
  end

endmodule

`default_nettype wire

// ===== hdl/dahdr_envelope_generator.sv =====
// DAHDR envelope generator.
// Input stream (s_*): one item per sample tick, s_tdata[0] is the key gate.
// Output stream (m_*): one item per input item, carrying the envelope level
// (Q1.16, 65536 = 1.0) in m_tdata[16:0] and the phase code in m_tdata[19:17]
// (0 idle, 1 delay, 2 attack, 3 hold, 4 decay, 5 release), both as they stand
// after that tick's update.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 delay
// ticks, 1 attack coef, 2 hold ticks, 3 decay coef, 4 sustain level,
// 5 release coef, 6 retrigger ticks). Write only while no item is in flight.
// An accepted item is first captured in the input register, and its result
// is then written into the state register, which drives m_*.
// Throughput: one item per clock while the receiver takes results. The whole
// envelope step (one 17x17 multiply, add and compare) runs between the input
// register and the state register, which doubles as the result register.
// Reset (rst, synchronous) clears the envelope to idle at level zero and
// loads the register defaults. When the receiver stalls, the result holds,
// one more item is taken into the input register, and then s_tready drops.
`default_nettype none

module dahdr_envelope_generator import dahdr_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [0] gate
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata,   // [16:0] level, [19:17] phase
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  env_cfg_t   cfg;
  env_state_t state;
  env_state_t state_next;
  logic       in_valid;
  logic       in_gate;
  logic       step_go;

  dahdr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dahdr_step u_step (
    .cfg     (cfg),
    .st      (state),
    .gate    (in_gate),
    .st_next (state_next)
  );

  assign step_go  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || step_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
      state    <= STATE_RESET;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (step_go) begin
        state    <= state_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_gate <= s_tdata[0];
    end
  end

  assign m_tdata = {{(OUT_TDATA_W - LEVEL_W - PHASE_W){1'b0}},
                    PHASE_W'(state.phase), state.level};

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    state.level <= ONE_LEVEL)
    else $error("envelope level above full scale");

  a_hold_full: assert property (@(posedge clk) disable iff (rst)
    state.phase == PH_HOLD |-> state.level == ONE_LEVEL)
    else $error("hold phase without full level");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    state.phase == PH_IDLE |-> state.level == '0)
    else $error("idle phase with nonzero level");

  a_input_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !step_go |=> in_valid && $stable(in_gate))
    else $error("buffered item lost while stalled");

endmodule

`default_nettype wire

// ===== sim/dahdr_checker.sv =====
module dahdr_checker import dahdr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [0] gate
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,   // [16:0] level, [19:17] phase
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     pending,
  output int                     ticks_checked,
  output logic [5:0]             phases_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    phase_t             phase;
    logic [LEVEL_W-1:0] level;
  } env_out_t;

  env_out_t   expected_levels[$];
  env_cfg_t   regs;
  env_state_t env;

  // Rounded Q0.16 fraction of a level distance.
  function automatic logic [LEVEL_W:0] coef_step(logic [LEVEL_W-1:0] c,
                                                 logic [LEVEL_W-1:0] d);
    logic [2*LEVEL_W+1:0] p;
    p = (2*LEVEL_W+2)'(c);
    p = p * d;
    p = p + (2*LEVEL_W+2)'(ONE_INT / 2);
    return p[LEVEL_FRAC_BITS +: LEVEL_W+1];
  endfunction

  function automatic logic [LEVEL_W-1:0] clip_one(logic [LEVEL_W-1:0] v);
    return (v > ONE_LEVEL) ? ONE_LEVEL : v;
  endfunction

  function automatic logic [TIME_BITS-1:0] count_up(logic [TIME_BITS-1:0] t);
    return (&t) ? t : t + 1'b1;
  endfunction

  function automatic env_out_t advance_envelope(logic gate);
    logic [LEVEL_W-1:0] c;
    logic [LEVEL_W-1:0] s;
    logic [LEVEL_W:0]   lv;
    env_out_t           r;
    // rising gate, or a held gate past the retrigger interval, restarts
    if (gate && (!env.prev_gate || (regs.retrigger_ticks != '0 &&
                                    env.key_timer >= regs.retrigger_ticks))) begin
      env.phase       = PH_DELAY;
      env.phase_timer = '0;
      env.key_timer   = '0;
    end
    case (env.phase)
      PH_DELAY: begin
        if (env.phase_timer >= regs.delay_ticks) begin
          env.phase       = PH_ATTACK;
          env.phase_timer = '0;
        end
      end
      PH_ATTACK: begin
        c = clip_one(regs.attack_coef);
        if (c == ONE_LEVEL) begin
          env.level       = ONE_LEVEL;
          env.phase       = PH_HOLD;
          env.phase_timer = '0;
        end else begin
          lv = {1'b0, clip_one(env.level)};
          lv = lv + coef_step(c, TARGET_ATTACK - lv[LEVEL_W-1:0]);
          if (lv >= {1'b0, ONE_LEVEL}) begin
            lv              = {1'b0, ONE_LEVEL};
            env.phase       = PH_HOLD;
            env.phase_timer = '0;
          end
          env.level = lv[LEVEL_W-1:0];
        end
      end
      PH_HOLD: begin
        if (env.phase_timer >= regs.hold_ticks) begin
          env.phase       = PH_DECAY;
          env.phase_timer = '0;
        end
      end
      PH_DECAY: begin
        s = clip_one(regs.sustain_level);
        // key up still takes this tick's decay step
        if (!gate) begin
          env.phase       = PH_RELEASE;
          env.phase_timer = '0;
        end
        c = clip_one(regs.decay_coef);
        if (c == ONE_LEVEL)
          env.level = s;
        else if (s >= env.level)
          env.level = env.level + LEVEL_W'(coef_step(c, s - env.level));
        else
          env.level = env.level - LEVEL_W'(coef_step(c, env.level - s));
      end
      PH_RELEASE: begin
        c = clip_one(regs.release_coef);
        if (c == ONE_LEVEL) begin
          env.level       = '0;
          env.phase       = PH_IDLE;
          env.phase_timer = '0;
        end else begin
          env.level = env.level - LEVEL_W'(coef_step(c, env.level));
        end
      end
      default: env.phase = PH_IDLE;
    endcase
    env.phase_timer = count_up(env.phase_timer);
    env.key_timer   = count_up(env.key_timer);
    env.prev_gate   = gate;
    r.phase = env.phase;
    r.level = env.level;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    env_out_t got;
    env_out_t want;
    if (rst) begin
      regs = CFG_RESET;
      env  = STATE_RESET;
      expected_levels.delete();
      mismatches    = 0;
      ticks_checked = 0;
      phases_seen   = '0;
    end else begin
      if ($isunknown(m_tvalid)) begin
        $error("m_tvalid is unknown after reset");
        mismatches++;
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_DELAY_TICKS:     regs.delay_ticks     = cfg_data[TIME_BITS-1:0];
          CFG_ATTACK_COEF:     regs.attack_coef     = cfg_data[LEVEL_W-1:0];
          CFG_HOLD_TICKS:      regs.hold_ticks      = cfg_data[TIME_BITS-1:0];
          CFG_DECAY_COEF:      regs.decay_coef      = cfg_data[LEVEL_W-1:0];
          CFG_SUSTAIN_LEVEL:   regs.sustain_level   = cfg_data[LEVEL_W-1:0];
          CFG_RELEASE_COEF:    regs.release_coef    = cfg_data[LEVEL_W-1:0];
          CFG_RETRIGGER_TICKS: regs.retrigger_ticks = cfg_data[TIME_BITS-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        expected_levels.push_back(advance_envelope(s_tdata[0]));
      if (m_tvalid && m_tready) begin
        got.level = m_tdata[LEVEL_W-1:0];
        got.phase = phase_t'(m_tdata[LEVEL_W +: PHASE_W]);
        if (expected_levels.size() == 0) begin
          $error("envelope item with no tick waiting: level %0d phase %0d",
                 got.level, got.phase);
          mismatches++;
        end else begin
          want = expected_levels.pop_front();
          ticks_checked++;
          phases_seen[want.phase] = 1'b1;
          if (got.level !== want.level) begin
            $error("level: expected %0d, got %0d", want.level, got.level);
            mismatches++;
          end
          if (got.phase !== want.phase) begin
            $error("phase: expected %0d, got %0d", want.phase, got.phase);
            mismatches++;
          end
        end
      end
    end
    pending = expected_levels.size();
  end

endmodule

// ===== sim/dahdr_envelope_generator_test.sv =====
module dahdr_envelope_generator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dahdr_pkg::*;

  localparam int STALL_CYCLES = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = '1;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int         mismatches;
  int         pending;
  int         ticks_checked;
  logic [5:0] phases_seen;

  bit stall_req = 1'b0;
  bit sender_gaps = 1'b0;
  int settings_applied = 0;

  dahdr_envelope_generator i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dahdr_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .pending       (pending),
    .ticks_checked (ticks_checked),
    .phases_seen   (phases_seen)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic int unsigned rand_ticks();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return 0;
    if (r < 8) return $urandom_range(1, 6);
    return $urandom_range(7, 60);
  endfunction

  function automatic int unsigned rand_coef();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r < 4) return ONE_INT;
    if (r == 4) return $urandom_range(ONE_INT + 1, 24'hFFFFFF);
    return $urandom_range(1500, ONE_INT - 1);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic offer_gate(input logic gate);
    int gap;
    gap = 0;
    if (sender_gaps && $urandom_range(0, 99) < 20)
      gap = idle_length();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'(gate);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic play_bits(input logic [31:0] bits, input int n);
    for (int i = n - 1; i >= 0; i--)
      offer_gate(bits[i]);
  endtask

  // Mostly key presses with random hold and rest, some random chatter.
  task automatic play_gates(input int n);
    int sent;
    int len;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) < 8) begin
        len = $urandom_range(1, 48);
        repeat (len) offer_gate(1'b1);
        sent += len;
        len = $urandom_range(1, 32);
        repeat (len) offer_gate(1'b0);
        sent += len;
      end else begin
        len = $urandom_range(1, 6);
        repeat (len) offer_gate(1'($urandom_range(0, 1)));
        sent += len;
      end
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Keep cfg_we high across back-to-back writes; the caller drops it after the last.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(negedge clk);
  endtask

  task automatic program_envelope(input int unsigned dly, input int unsigned atk,
                                  input int unsigned hld, input int unsigned dcy,
                                  input int unsigned sus, input int unsigned rel,
                                  input int unsigned rtg);
    drain();
    write_reg(CFG_DELAY_TICKS, dly);
    write_reg(CFG_ATTACK_COEF, atk);
    write_reg(CFG_HOLD_TICKS, hld);
    write_reg(CFG_DECAY_COEF, dcy);
    write_reg(CFG_SUSTAIN_LEVEL, sus);
    write_reg(CFG_RELEASE_COEF, rel);
    write_reg(CFG_RETRIGGER_TICKS, rtg);
    write_reg(CFG_UNUSED, $urandom_range(0, 24'hFFFFFF));
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  initial begin : result_sink
    int   len;
    logic rdy;
    forever begin
      if (stall_req) begin
        stall_req = 1'b0;
        m_tready <= 1'b0;
        repeat (STALL_CYCLES) @(negedge clk);
      end else begin
        if ($urandom_range(0, 99) < 70) begin
          rdy = 1'b1;
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                            : $urandom_range(1, 8);
        end else begin
          rdy = 1'b0;
          len = idle_length();
        end
        m_tready <= rdy;
        do begin
          @(negedge clk);
          len--;
        end while (len > 0 && !stall_req);
      end
    end
  end

  initial begin : stimulus
    int unsigned sus;
    int unsigned rtg;
    int          r;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset registers: every step instant, instant release ends in idle
    play_bits(32'b0111100101, 10);
    // gate low in delay ignored, held-gate retrigger, values above one
    program_envelope(2, 24'h1FFFF, 2, 20000, 24'h1FFFF, 30000, 6);
    play_bits(32'b1001111111000, 13);

    // extremes: timers that never run out or run out at once, coefficients that never move
    sender_gaps = 1'b1;
    program_envelope(24'hFFFFFF, 0, 24'hFFFFFF, 0, 0, 0, 24'hFFFFFF);
    play_gates(40);
    program_envelope(0, 0, 0, 0, 0, 0, 1);
    play_gates(40);

    for (int k = 0; k < 11; k++) begin
      r = $urandom_range(0, 9);
      sus = (r == 0) ? 0 :
            (r == 1) ? ONE_INT :
            (r == 2) ? $urandom_range(ONE_INT + 1, 24'hFFFFFF) :
                       $urandom_range(0, ONE_INT - 1);
      rtg = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(3, 60);
      program_envelope(rand_ticks(), rand_coef(), rand_ticks(), rand_coef(),
                       sus, rand_coef(), rtg);
      sender_gaps = !(k == 1 || k == 2 || k == 6);
      if (k == 2)
        stall_req = 1'b1;
      if (k == 5) begin
        play_gates(35);
        // hold the input until the output side has caught up
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        play_gates(35);
      end else begin
        play_gates(70);
      end
    end

    drain();
    repeat (10) @(negedge clk);
    $display("Checked %0d envelope ticks under %0d register settings",
             ticks_checked, settings_applied);
    $display("Phases reached (release..idle): %b", phases_seen);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/dahdr_pkg.sv
hdl/dahdr_cfg.sv
hdl/dahdr_step.sv
hdl/dahdr_envelope_generator.sv
sim/dahdr_checker.sv
sim/dahdr_envelope_generator_test.sv
